@@ src/mk_pkg.sv @@
// Shared types and constants of the 3-D Morton key block.
`default_nettype none
package mk_pkg;
  localparam int GridBitsDef = 21;
  localparam int KeyWidthDef = 64;
  localparam int CoordW      = 32;
  localparam int MagW        = CoordW + 1;
  localparam int KeyW        = 64;
  localparam int NumAxes     = 3;
  localparam int CfgIdxW     = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegCornerX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCornerY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCornerZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSpanX   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpanY   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSpanZ   = 3'd5;

  // one axis after the corner subtraction
  typedef struct packed {
    logic [MagW-1:0] mag;
    logic            neg;
  } axis_t;

  // one queued item, axis 0 = x, 1 = y, 2 = z
  typedef axis_t [NumAxes-1:0] item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;
endpackage
`default_nettype wire

@@ src/mk_if.sv @@
// Valid/ready channel interfaces for positions and keys.
`default_nettype none
interface mk_pos_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface mk_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] key;
  logic        clamped;
  modport source (output valid, key, clamped, input ready);
  modport sink (input valid, key, clamped, output ready);
endinterface
`default_nettype wire

@@ src/mk_front.sv @@
// Front end: accepts positions, subtracts the corner, queues the result.
`default_nettype none
module mk_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  mk_pos_if.sink                             pos_ch,
  input  wire logic [mk_pkg::CoordW-1:0]     corner [mk_pkg::NumAxes],
  input  wire logic                          pop,
  output mk_pkg::head_t                      head
);
  import mk_pkg::*;

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      item_new;
  logic       push;
  logic       do_pop;

  logic signed [MagW-1:0] diff [NumAxes];
  logic [CoordW-1:0]      pos_v [NumAxes];

  assign pos_v[0] = pos_ch.pos_x;
  assign pos_v[1] = pos_ch.pos_y;
  assign pos_v[2] = pos_ch.pos_z;

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      diff[a] = $signed({pos_v[a][CoordW-1], pos_v[a]})
              - $signed({corner[a][CoordW-1], corner[a]});
      item_new[a].neg = diff[a][MagW-1];
      item_new[a].mag = diff[a][MagW-1] ? MagW'(-diff[a]) : MagW'(diff[a]);
    end
  end

  assign pos_ch.ready = (count != 2'd2);
  assign push         = pos_ch.valid && pos_ch.ready;
  assign do_pop       = pop && (count != 2'd0);
  assign head.valid   = (count != 2'd0);
  assign head.item    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= item_new;
  end
endmodule
`default_nettype wire

@@ src/mk_back.sv @@
// Back end: pipelined restoring division per axis and key interleave.
`default_nettype none
module mk_back #(
  parameter int GRID_BITS = mk_pkg::GridBitsDef,
  parameter int KEY_WIDTH = mk_pkg::KeyWidthDef
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mk_pkg::head_t             head,
  output logic                           pop,
  input  wire logic [mk_pkg::CoordW-1:0] span [mk_pkg::NumAxes],
  mk_key_if.source                       key_ch
);
  import mk_pkg::*;

  typedef struct packed {
    logic [MagW-1:0]      rem;
    logic [GRID_BITS-1:0] q;
    logic                 neg;
    logic                 big;
  } lane_t;

  lane_t              st [NumAxes][GRID_BITS+1];
  logic [GRID_BITS:0] vld;
  logic [MagW-1:0]    div [NumAxes];
  logic               adv;
  logic               out_valid;
  logic [KeyW-1:0]    key_next;
  logic               clamped_next;
  logic [GRID_BITS-1:0] idx [NumAxes];

  // zero span acts as one
  always_comb begin
    for (int a = 0; a < NumAxes; a++)
      div[a] = (span[a] == '0) ? MagW'(1) : {1'b0, span[a]};
  end

  assign adv = !out_valid || key_ch.ready;
  assign pop = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[GRID_BITS-1:0], head.valid};
      out_valid <= vld[GRID_BITS];
    end
  end

  // stage 0 classifies; stage s+1 yields quotient bit GRID_BITS-1-s
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < NumAxes; a++) begin
        st[a][0].neg <= head.item[a].neg;
        st[a][0].big <= (head.item[a].mag >= div[a]);
        st[a][0].rem <= (head.item[a].mag >= div[a]) ? '0 : head.item[a].mag;
        st[a][0].q   <= '0;
        for (int s = 0; s < GRID_BITS; s++) begin
          st[a][s+1].neg <= st[a][s].neg;
          st[a][s+1].big <= st[a][s].big;
          if ({st[a][s].rem[MagW-2:0], 1'b0} >= div[a]) begin
            st[a][s+1].rem <= {st[a][s].rem[MagW-2:0], 1'b0} - div[a];
            st[a][s+1].q   <= (st[a][s].q << 1) | GRID_BITS'(1);
          end else begin
            st[a][s+1].rem <= {st[a][s].rem[MagW-2:0], 1'b0};
            st[a][s+1].q   <= st[a][s].q << 1;
          end
        end
      end
    end
  end

  always_comb begin
    clamped_next = 1'b0;
    for (int a = 0; a < NumAxes; a++) begin
      if (st[a][GRID_BITS].neg) begin
        idx[a] = '0;
        if (st[a][GRID_BITS].big || st[a][GRID_BITS].q != '0) clamped_next = 1'b1;
      end else if (st[a][GRID_BITS].big) begin
        idx[a] = '1;
        clamped_next = 1'b1;
      end else begin
        idx[a] = st[a][GRID_BITS].q;
      end
    end
    key_next = '0;
    key_next[KEY_WIDTH-1] = 1'b1;
    for (int j = 0; j < GRID_BITS; j++) begin
      if (3*j < KEY_WIDTH-1)   key_next[3*j]   = idx[2][j];
      if (3*j+1 < KEY_WIDTH-1) key_next[3*j+1] = idx[1][j];
      if (3*j+2 < KEY_WIDTH-1) key_next[3*j+2] = idx[0][j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_ch.key     <= key_next;
      key_ch.clamped <= clamped_next;
    end
  end

  assign key_ch.valid = out_valid;
endmodule
`default_nettype wire

@@ src/morton_key_3d.sv @@
// Top level of the 3-D Morton key block.
// Usage:
//   pos_ch carries one particle position per item (pos_x, pos_y, pos_z).
//   key_ch returns one item per position: the interleaved grid key with a
//   leading one at bit KEY_WIDTH-1, and clamped when any axis saturated.
//   Configuration (corner and span per axis) is written through cfg_we,
//   cfg_idx, cfg_data while no item is in flight; unknown indexes are ignored.
// Path: an accepted item leaves the queue into the classify stage, then
//   passes GRID_BITS divide stages and the output register.
// Throughput: one item per cycle while the output is not held; each axis has
//   its own restoring divider pipelined one quotient bit per stage.
// Reset: synchronous rst empties the queue and pipeline, corners go to 0
//   and spans to 1.
// Stall: a held output freezes the divide pipeline; the two-entry queue
//   keeps taking items until full, then pos_ch.ready drops.
`default_nettype none
module morton_key_3d #(
  parameter int GRID_BITS = mk_pkg::GridBitsDef,
  parameter int KEY_WIDTH = mk_pkg::KeyWidthDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [mk_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [mk_pkg::CoordW-1:0]  cfg_data,
  mk_pos_if.sink                          pos_ch,
  mk_key_if.source                        key_ch
);
  import mk_pkg::*;

  logic [CoordW-1:0] corner [NumAxes];
  logic [CoordW-1:0] span [NumAxes];
  head_t             head;
  logic              pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NumAxes; a++) begin
        corner[a] <= '0;
        span[a]   <= CoordW'(1);
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        RegCornerX: corner[0] <= cfg_data;
        RegCornerY: corner[1] <= cfg_data;
        RegCornerZ: corner[2] <= cfg_data;
        RegSpanX:   span[0]   <= cfg_data;
        RegSpanY:   span[1]   <= cfg_data;
        RegSpanZ:   span[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: corner subtraction and item queue
  mk_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pos_ch (pos_ch),
    .corner (corner),
    .pop    (pop),
    .head   (head)
  );

  // back: division pipeline, saturation, interleave
  mk_back #(
    .GRID_BITS (GRID_BITS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .span   (span),
    .key_ch (key_ch)
  );
endmodule
`default_nettype wire

@@ src/mk_check.sv @@
// Port-level checks of the Morton key block and their bind.
`default_nettype none
module mk_check #(
  parameter int KEY_WIDTH = mk_pkg::KeyWidthDef
) (
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  key_valid,
  input wire logic  key_ready,
  input wire logic [63:0] key
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    key_valid && !key_ready |=> key_valid)
    else $error("key item dropped under stall");

  a_lead: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> key[KEY_WIDTH-1])
    else $error("leading one missing");

  a_high: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> (key >> KEY_WIDTH) == 64'd0)
    else $error("key bits above width set");

  a_rst: assert property (@(posedge clk) rst |=> !key_valid)
    else $error("output valid after reset");
endmodule

bind morton_key_3d mk_check #(.KEY_WIDTH(KEY_WIDTH)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .key_valid (key_ch.valid),
  .key_ready (key_ch.ready),
  .key       (key_ch.key)
);
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench of the 3-D Morton key block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mk_pkg::*;

  localparam int GB = GridBitsDef;
  localparam int KWD = KeyWidthDef;
  localparam int LATENCY = GB + 3;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM = 1530;

  typedef struct packed {
    logic [63:0] key;
    logic        clamped;
  } key_res_t;

  // directed row: position plus optional typed-in result
  typedef struct packed {
    logic [31:0] px, py, pz;
    logic        known;
    key_res_t    res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CoordW-1:0] cfg_data = '0;

  mk_pos_if pos_ch();
  mk_key_if key_ch();

  morton_key_3d uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .pos_ch(pos_ch.sink), .key_ch(key_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor's copy of the registers
  logic [31:0] corner [3];
  logic [31:0] span [3];

  key_res_t pending_keys[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_sink = 1'b0;      // long receiver stall
  bit sink_rand = 1'b1;

  // grid index along one axis, saturated into range
  function automatic logic [GB-1:0] grid_index(logic [31:0] p, logic [31:0] c,
                                               logic [31:0] s, ref bit sat);
    logic signed [32:0] d;
    logic [32:0] mag;
    logic [63:0] q, dv;
    d = $signed({p[31], p}) - $signed({c[31], c});
    mag = d[32] ? -d : d;
    dv = (s == 0) ? 64'd1 : {32'd0, s};
    q = ({31'd0, mag} << GB) / dv;
    if (d[32]) begin
      if (q != 0) sat = 1'b1;
      return '0;
    end
    if (q >= (64'd1 << GB)) begin
      sat = 1'b1;
      return '1;
    end
    return q[GB-1:0];
  endfunction

  function automatic key_res_t morton_of(logic [31:0] px, logic [31:0] py,
                                         logic [31:0] pz);
    bit sat;
    logic [GB-1:0] xi, yi, zi;
    key_res_t r;
    sat = 1'b0;
    xi = grid_index(px, corner[0], span[0], sat);
    yi = grid_index(py, corner[1], span[1], sat);
    zi = grid_index(pz, corner[2], span[2], sat);
    r.key = 64'd1 << (KWD - 1);
    for (int j = 0; j < GB; j++) begin
      if (3*j < KWD-1) r.key[3*j] = zi[j];
      if (3*j+1 < KWD-1) r.key[3*j+1] = yi[j];
      if (3*j+2 < KWD-1) r.key[3*j+2] = xi[j];
    end
    r.clamped = sat;
    return r;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegCornerX: corner[0] = val;
      RegCornerY: corner[1] = val;
      RegCornerZ: corner[2] = val;
      RegSpanX: span[0] = val;
      RegSpanY: span[1] = val;
      RegSpanZ: span[2] = val;
      default: ;
    endcase
  endtask

  // called at a falling edge right after the last accepted item
  task automatic drain();
    pos_ch.valid <= 1'b0;
    wait (pending_keys.size() == 0);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  int unsigned gap_len;
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one position at a falling edge; returns at the falling edge after
  // it is accepted, with valid still high so the next item can follow
  task automatic send_pos(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                          bit no_gap);
    gap_len = no_gap ? 0 : rand_gap();
    if (gap_len != 0) begin
      pos_ch.valid <= 1'b0;
      repeat (gap_len) @(negedge clk);
    end
    pos_ch.valid <= 1'b1;
    pos_ch.pos_x <= px;
    pos_ch.pos_y <= py;
    pos_ch.pos_z <= pz;
    do @(posedge clk); while (!pos_ch.ready);
    pending_keys.insert(pending_keys.size(), morton_of(px, py, pz));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      default: return corner[$urandom_range(0, 2)] + $urandom_range(0, 4096);
    endcase
  endfunction

  function automatic logic [31:0] rand_span();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom_range(1, 16);
      default: return $urandom;
    endcase
  endfunction

  // receiver: random ready unless held or sink_rand is 0, sample at posedge
  initial begin
    key_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink) key_ch.ready <= 1'b0;
      else if (!sink_rand) key_ch.ready <= 1'b1;
      else key_ch.ready <= (rand_gap() == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && key_ch.valid && key_ch.ready) begin
      if (pending_keys.size() == 0) begin
        $error("key item with no expectation waiting");
        errors++;
      end else begin
        key_res_t want;
        want = pending_keys.pop_front();
        if (key_ch.key !== want.key) begin
          $error("key: expected %h actual %h", want.key, key_ch.key);
          errors++;
        end
        if (key_ch.clamped !== want.clamped) begin
          $error("clamped: expected %b actual %b", want.clamped, key_ch.clamped);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted item on either channel
  always @(posedge clk) begin
    if ((pos_ch.valid && pos_ch.ready) || (key_ch.valid && key_ch.ready))
      idle_cycles = 0;
    else if (!hold_sink)
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  row_t rows[$];
  localparam logic [63:0] Top = 64'h8000_0000_0000_0000;

  initial begin
    pos_ch.valid = 1'b0;
    pos_ch.pos_x = '0;
    pos_ch.pos_y = '0;
    pos_ch.pos_z = '0;
    corner = '{default: 32'd0};
    span = '{default: 32'd1};
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // after reset: span 1, so any positive coordinate saturates
    rows.insert(rows.size(), '{32'd0, 32'd0, 32'd0, 1'b1, '{Top, 1'b0}});
    rows.insert(rows.size(), '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1,
                               '{64'hffff_ffff_ffff_ffff, 1'b1}});
    rows.insert(rows.size(), '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
                               '{Top, 1'b1}});
    rows.insert(rows.size(), '{32'd1, 32'd0, 32'd0, 1'b0, '0});
    rows.insert(rows.size(), '{32'd0, 32'hffff_ffff, 32'd0, 1'b0, '0});
    foreach (rows[i]) begin
      send_pos(rows[i].px, rows[i].py, rows[i].pz, 1'b1);
      if (rows[i].known && pending_keys[$] !== rows[i].res) begin
        $error("table row %0d: expected %h/%b predicted %h/%b", i, rows[i].res.key,
               rows[i].res.clamped, pending_keys[$].key, pending_keys[$].clamped);
        errors++;
      end
    end
    drain();

    // box with upper face, below-box truncation, zero span, ignored index
    write_reg(RegCornerX, 32'hffff_ff00);
    write_reg(RegCornerY, 32'd100);
    write_reg(RegCornerZ, 32'h8000_0000);
    write_reg(RegSpanX, 32'd512);
    write_reg(RegSpanY, 32'hffff_ffff);
    write_reg(RegSpanZ, 32'd0);
    write_reg(3'd6, 32'hdead_beef);
    write_reg(3'd7, 32'h1234_5678);
    send_pos(32'hffff_ff00, 32'd100, 32'h8000_0000, 1'b1);
    send_pos(32'd256, 32'd99, 32'h8000_0000, 1'b1);       // upper face x
    send_pos(32'hffff_fe00, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    send_pos(32'hffff_feff, 32'd0, 32'h8000_0001, 1'b1);
    send_pos(32'd255, 32'h8000_0000, 32'h8000_0000, 1'b1);
    drain();

    // long receiver stall while the sender keeps offering
    fork
      begin
        hold_sink = 1'b1;
        repeat (200) @(negedge clk);
        hold_sink = 1'b0;
      end
      begin
        for (int i = 0; i < 40; i++) send_pos($urandom, $urandom, $urandom, 1'b1);
      end
    join
    drain();

    // random phases, each with new register settings
    for (int ph = 0; ph < 10; ph++) begin
      for (int r = 0; r < 3; r++) write_reg(CfgIdxW'(RegCornerX + r), $urandom);
      for (int r = 0; r < 3; r++) write_reg(CfgIdxW'(RegSpanX + r), rand_span());
      sink_rand = (ph % 3 != 2);
      for (int i = 0; i < N_RANDOM / 10 - 5; i++)
        send_pos(rand_coord(), rand_coord(), rand_coord(), ph % 3 == 2);
      drain();
    end
    sink_rand = 1'b1;

    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

@@ filelist.f @@
src/mk_pkg.sv
src/mk_if.sv
src/mk_front.sv
src/mk_back.sv
src/morton_key_3d.sv
src/mk_check.sv
tb/sv/testbench.sv
